FILE: design/alignment_qc_accumulator_unit_assert.svh
// ----------------------------------------------------------------------------
// Alignment QC accumulator assertion macros
// Concurrent checks clocked on i_clk, switched off as a group by NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_QC_ACCUMULATOR_UNIT_ASSERT_SVH
`define ALIGNMENT_QC_ACCUMULATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge outside reset
`define AQA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// property that looks back at earlier values, skipped on the first edge after reset
`define AQA_ASSERT_RUN(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        ($past(i_rst_n) && (ante)) |-> (cons)) else $error(msg);

`else

`define AQA_ASSERT(label, prop, msg)
`define AQA_ASSERT_RUN(label, ante, cons, msg)

`endif

`endif

FILE: design/aqa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alignment QC accumulator package
// Shared field widths, request codes, payload types and saturating helpers
// ----------------------------------------------------------------------------
package aqa_pkg;

    localparam int LEN_W = 16;
    localparam int CNT_W = 32;
    localparam int SUM_W = 48;
    localparam int MQ_W  = 8;
    localparam int INS_W = 32;
    localparam int IDX_W = 8;

    // request kinds
    localparam logic FUNC_RECORD   = 1'b0;
    localparam logic FUNC_BIN_READ = 1'b1;

    // one alignment request as registered at the input
    typedef struct packed {
        logic                    func;
        logic [LEN_W-1:0]        read_length;
        logic                    is_paired;
        logic                    is_primary;
        logic                    is_proper_pair;
        logic                    is_mapped;
        logic                    is_duplicate;
        logic                    on_main_chromosome;
        logic [MQ_W-1:0]         map_quality;
        logic signed [INS_W-1:0] insert_size;
        logic [IDX_W-1:0]        bin_index;
    } t_aqa_rec;

    // counter snapshot carried with every request
    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] mapped;
        logic [CNT_W-1:0] target;
        logic [CNT_W-1:0] dup;
        logic [CNT_W-1:0] proper;
        logic [SUM_W-1:0] trimmed;
        logic [SUM_W-1:0] insert;
        logic [SUM_W-1:0] tbases;
        logic [LEN_W-1:0] max_len;
        logic             paired;
    } t_aqa_snap;

    // per-request control travelling down the pipeline
    typedef struct packed {
        logic func;
        logic rd_ok;
        logic inc;
    } t_aqa_meta;

    // increment that sticks at all ones
    function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] a);
        logic [CNT_W-1:0] r;
        r = (a == '1) ? a : a + 1'b1;
        return r;
    endfunction

    // add that sticks at all ones
    function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

endpackage

FILE: design/aqa_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alignment QC accumulator channels
// Valid/ready channels for alignment requests, results and the config write
// ----------------------------------------------------------------------------

// alignment request channel
interface aqa_rec_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    func;
    logic [aqa_pkg::LEN_W-1:0]               read_length;
    logic                                    is_paired;
    logic                                    is_primary;
    logic                                    is_proper_pair;
    logic                                    is_mapped;
    logic                                    is_duplicate;
    logic                                    on_main_chromosome;
    logic [aqa_pkg::MQ_W-1:0]                map_quality;
    logic signed [aqa_pkg::INS_W-1:0]        insert_size;
    logic [aqa_pkg::IDX_W-1:0]               bin_index;

    modport source (output valid, func, read_length, is_paired, is_primary,
                    is_proper_pair, is_mapped, is_duplicate, on_main_chromosome,
                    map_quality, insert_size, bin_index, input ready);
    modport sink   (input valid, func, read_length, is_paired, is_primary,
                    is_proper_pair, is_mapped, is_duplicate, on_main_chromosome,
                    map_quality, insert_size, bin_index, output ready);
endinterface

// result channel
interface aqa_res_if;
    logic                          valid;
    logic                          ready;
    logic [aqa_pkg::CNT_W-1:0]     total_count;
    logic [aqa_pkg::CNT_W-1:0]     mapped_count;
    logic [aqa_pkg::CNT_W-1:0]     target_count;
    logic [aqa_pkg::CNT_W-1:0]     dup_count;
    logic [aqa_pkg::CNT_W-1:0]     proper_count;
    logic [aqa_pkg::SUM_W-1:0]     trimmed_total;
    logic [aqa_pkg::SUM_W-1:0]     insert_total;
    logic [aqa_pkg::SUM_W-1:0]     target_bases;
    logic [aqa_pkg::LEN_W-1:0]     max_read_length;
    logic                          paired_flag;
    logic [aqa_pkg::CNT_W-1:0]     bin_value;

    modport source (output valid, total_count, mapped_count, target_count,
                    dup_count, proper_count, trimmed_total, insert_total,
                    target_bases, max_read_length, paired_flag, bin_value,
                    input ready);
    modport sink   (input valid, total_count, mapped_count, target_count,
                    dup_count, proper_count, trimmed_total, insert_total,
                    target_bases, max_read_length, paired_flag, bin_value,
                    output ready);
endinterface

// configuration write channel
interface aqa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [aqa_pkg::MQ_W-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: design/aqa_hist.sv
`timescale 1ns / 1ps
`include "alignment_qc_accumulator_unit_assert.svh"
// ----------------------------------------------------------------------------
// Insert-size histogram store
// Bin memory with registered read, saturating read-modify-write increment,
// write-to-read forwarding and a clearing pass after reset
// ----------------------------------------------------------------------------
module aqa_hist #(
    parameter int unsigned HIST_BINS = 200
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rd_en,
    input  logic [$clog2(HIST_BINS)-1:0]          i_rd_addr,
    input  logic                                  i_upd_en,
    output logic [aqa_pkg::CNT_W-1:0]             o_rd_data,
    output logic                                  o_clearing
);

    localparam int AW = $clog2(HIST_BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HIST_BINS - 1);

    logic [aqa_pkg::CNT_W-1:0] mem [HIST_BINS];

    logic [AW-1:0]             r_addr;
    logic [aqa_pkg::CNT_W-1:0] r_data;
    logic                      r_clearing;
    logic [AW-1:0]             r_clr_addr;

    logic [aqa_pkg::CNT_W-1:0] upd_val;
    logic                      fwd;

    // incremented bin value, forwarded when the next read hits the same bin
    assign upd_val = aqa_pkg::sat_inc32(r_data);
    assign fwd     = i_upd_en && (i_rd_addr == r_addr);

    // clearing sweep after reset, one bin a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // bin memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_upd_en) begin
            mem[r_addr] <= upd_val;
        end
        if (i_rd_en) begin
            r_addr <= i_rd_addr;
            r_data <= fwd ? upd_val : mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_data;
    assign o_clearing = r_clearing;

    `AQA_ASSERT(a_quiet_clear, (r_clearing |-> (!i_rd_en && !i_upd_en)), "access during clear")
    `AQA_ASSERT_RUN(a_clear_len, $fell(r_clearing), $past(r_clr_addr) == LAST_ADDR, "short clear")
    `AQA_ASSERT_RUN(a_clear_step, $past(r_clearing) && r_clearing, r_clr_addr == AW'($past(r_clr_addr) + 1'b1), "clear skipped a bin")

endmodule

FILE: design/alignment_qc_accumulator_unit.sv
`timescale 1ns / 1ps
`include "alignment_qc_accumulator_unit_assert.svh"
// ----------------------------------------------------------------------------
// Alignment QC accumulator
// Read-alignment statistics: saturating counters, base sums, running longest
// read and an insert-size histogram readable one bin per request
// ----------------------------------------------------------------------------
//  channel  direction  handshake          carries
//  i_rec    in         valid / ready      alignment record or bin-read request
//  o_res    out        valid / ready      counter snapshot and bin value
//  i_cfg    in         valid / ready      min_map_quality write (always ready)
//
//  One request per cycle unless o_res.ready stalls a full pipeline or a clear runs.
//  Stage chain: input reg, counters, reciprocal multiply, bin clamp and
//  memory read, increment and write back, result reg.
//  After reset the histogram is swept to zero over all HIST_BINS bins (200 by
//  default) with i_rec.ready low; config writes are taken throughout.
//  o_res.ready low holds the result; bubbles close up, so requests are still
//  taken until all five stages are full.
// ----------------------------------------------------------------------------
module alignment_qc_accumulator_unit #(
    parameter int unsigned HIST_BINS  = 200,
    parameter int unsigned BIN_WIDTH  = 5,
    parameter int unsigned INSERT_CAP = 999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aqa_rec_if.sink     i_rec,
    aqa_res_if.source   o_res,
    aqa_cfg_if.sink     i_cfg
);

    localparam int AW        = $clog2(HIST_BINS);
    localparam int CAP_W     = $clog2(INSERT_CAP + 1);
    // x / BIN_WIDTH as (x * RECIP) >> SHIFT, exact for x below 2**CAP_W
    localparam int SHIFT     = CAP_W + 7;
    localparam int RECIP_W   = SHIFT + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(BIN_WIDTH) - 64'd1) / 64'(BIN_WIDTH);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
    localparam logic [AW-1:0]      LAST_BIN = AW'(HIST_BINS - 1);
    localparam int PROD_W    = CAP_W + RECIP_W;

    // stage valids and payloads
    logic                          r_v1, r_v2, r_v3, r_v4, r_o_valid;
    aqa_pkg::t_aqa_rec             r_s1;
    aqa_pkg::t_aqa_snap            r_s2_snap, r_s3_snap, r_s4_snap, r_o_snap;
    aqa_pkg::t_aqa_meta            r_s2_meta, r_s3_meta, r_s4_meta;
    logic [CAP_W-1:0]              r_s2_capped;
    logic [AW-1:0]                 r_s2_rd_addr, r_s3_rd_addr;
    logic [CAP_W-1:0]              r_s3_quot;
    logic [aqa_pkg::CNT_W-1:0]     r_o_bin;

    // state
    aqa_pkg::t_aqa_snap            r_cnt, n_cnt;
    logic [aqa_pkg::MQ_W-1:0]      r_min_mq;

    // handshake chain
    logic take_o, take4, take3, take2, take1;
    logic mv1, mv3, mv4, acc;
    logic clearing;

    // stage-one logic
    logic [aqa_pkg::INS_W-1:0]     raw;
    logic [aqa_pkg::INS_W-1:0]     mag;
    logic [CAP_W-1:0]              capped;
    logic [aqa_pkg::LEN_W-1:0]     new_max;
    logic                          pp, inc, rd_ok;
    logic [AW-1:0]                 rd_addr;

    // later stages
    logic [PROD_W-1:0]             prod;
    logic [AW-1:0]                 bin, mem_addr;
    logic [aqa_pkg::CNT_W-1:0]     hist_data, bin_val;

    // request intake, stalls close bubbles stage by stage
    assign take_o      = !r_o_valid || o_res.ready;
    assign take4       = !r_v4 || take_o;
    assign take3       = !r_v3 || take4;
    assign take2       = !r_v2 || take3;
    assign take1       = !r_v1 || take2;
    assign mv4         = r_v4 && take_o;
    assign mv3         = r_v3 && take4;
    assign mv1         = r_v1 && take2;
    assign i_rec.ready = take1 && !clearing;
    assign acc         = i_rec.valid && i_rec.ready;

    // config register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mq <= '0;
        end else if (i_cfg.valid) begin
            r_min_mq <= i_cfg.data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (take1)  r_v1      <= acc;
            if (take2)  r_v2      <= r_v1;
            if (take3)  r_v3      <= r_v2;
            if (take4)  r_v4      <= r_v3;
            if (take_o) r_o_valid <= r_v4;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1.func               <= i_rec.func;
            r_s1.read_length        <= i_rec.read_length;
            r_s1.is_paired          <= i_rec.is_paired;
            r_s1.is_primary         <= i_rec.is_primary;
            r_s1.is_proper_pair     <= i_rec.is_proper_pair;
            r_s1.is_mapped          <= i_rec.is_mapped;
            r_s1.is_duplicate       <= i_rec.is_duplicate;
            r_s1.on_main_chromosome <= i_rec.on_main_chromosome;
            r_s1.map_quality        <= i_rec.map_quality;
            r_s1.insert_size        <= i_rec.insert_size;
            r_s1.bin_index          <= i_rec.bin_index;
        end
    end

    // magnitude of insert size, capped; most negative value comes out as 2**31
    assign raw    = unsigned'(r_s1.insert_size);
    assign mag    = raw[aqa_pkg::INS_W-1] ? (~raw + 1'b1) : raw;
    assign capped = (mag > aqa_pkg::INS_W'(INSERT_CAP)) ? CAP_W'(INSERT_CAP) : CAP_W'(mag);

    // flag decode and bin-read address
    assign pp      = r_s1.is_paired && r_s1.is_primary;
    assign inc     = pp && r_s1.is_proper_pair;
    assign new_max = (r_s1.read_length > r_cnt.max_len) ? r_s1.read_length : r_cnt.max_len;
    assign rd_ok   = 32'(r_s1.bin_index) < 32'(HIST_BINS);
    assign rd_addr = rd_ok ? AW'(r_s1.bin_index) : '0;

    // counter update for one record
    always_comb begin
        n_cnt = r_cnt;
        if (r_s1.func == aqa_pkg::FUNC_RECORD) begin
            n_cnt.total   = aqa_pkg::sat_inc32(r_cnt.total);
            n_cnt.max_len = new_max;
            if (pp) begin
                n_cnt.paired = 1'b1;
            end
            if (inc) begin
                n_cnt.proper = aqa_pkg::sat_inc32(r_cnt.proper);
                n_cnt.insert = aqa_pkg::sat_add48(r_cnt.insert, aqa_pkg::SUM_W'(capped));
            end
            if (r_s1.is_mapped) begin
                n_cnt.mapped = aqa_pkg::sat_inc32(r_cnt.mapped);
                if (r_s1.on_main_chromosome) begin
                    n_cnt.target = aqa_pkg::sat_inc32(r_cnt.target);
                    if (r_s1.is_primary && !r_s1.is_duplicate
                            && r_s1.map_quality >= r_min_mq) begin
                        n_cnt.tbases = aqa_pkg::sat_add48(r_cnt.tbases,
                            aqa_pkg::SUM_W'(r_s1.read_length));
                    end
                end
            end
            if (r_s1.read_length < new_max) begin
                n_cnt.trimmed = aqa_pkg::sat_add48(r_cnt.trimmed,
                    aqa_pkg::SUM_W'(new_max - r_s1.read_length));
            end
            if (r_s1.is_duplicate) begin
                n_cnt.dup = aqa_pkg::sat_inc32(r_cnt.dup);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (mv1) begin
            r_cnt <= n_cnt;
        end
    end

    // stage two register
    always_ff @(posedge i_clk) begin
        if (take2) begin
            r_s2_snap     <= n_cnt;
            r_s2_meta     <= '{func: r_s1.func, rd_ok: rd_ok,
                               inc: inc && (r_s1.func == aqa_pkg::FUNC_RECORD)};
            r_s2_capped   <= capped;
            r_s2_rd_addr  <= rd_addr;
        end
    end

    // bin number by reciprocal multiply
    assign prod = PROD_W'(r_s2_capped) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (take3) begin
            r_s3_snap    <= r_s2_snap;
            r_s3_meta    <= r_s2_meta;
            r_s3_quot    <= prod[SHIFT +: CAP_W];
            r_s3_rd_addr <= r_s2_rd_addr;
        end
    end

    // clamp to the last bin and pick the memory address
    assign bin      = (32'(r_s3_quot) >= 32'(HIST_BINS - 1)) ? LAST_BIN : AW'(r_s3_quot);
    assign mem_addr = r_s3_meta.inc ? bin : r_s3_rd_addr;

    always_ff @(posedge i_clk) begin
        if (take4) begin
            r_s4_snap <= r_s3_snap;
            r_s4_meta <= r_s3_meta;
        end
    end

    // histogram memory
    aqa_hist #(
        .HIST_BINS (HIST_BINS)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (mv3),
        .i_rd_addr  (mem_addr),
        .i_upd_en   (mv4 && r_s4_meta.inc),
        .o_rd_data  (hist_data),
        .o_clearing (clearing)
    );

    // result register
    assign bin_val = (r_s4_meta.func == aqa_pkg::FUNC_BIN_READ && r_s4_meta.rd_ok)
                     ? hist_data : '0;

    always_ff @(posedge i_clk) begin
        if (take_o) begin
            r_o_snap <= r_s4_snap;
            r_o_bin  <= bin_val;
        end
    end

    assign o_res.valid           = r_o_valid;
    assign o_res.total_count     = r_o_snap.total;
    assign o_res.mapped_count    = r_o_snap.mapped;
    assign o_res.target_count    = r_o_snap.target;
    assign o_res.dup_count       = r_o_snap.dup;
    assign o_res.proper_count    = r_o_snap.proper;
    assign o_res.trimmed_total   = r_o_snap.trimmed;
    assign o_res.insert_total    = r_o_snap.insert;
    assign o_res.target_bases    = r_o_snap.tbases;
    assign o_res.max_read_length = r_o_snap.max_len;
    assign o_res.paired_flag     = r_o_snap.paired;
    assign o_res.bin_value       = r_o_bin;

    `AQA_ASSERT_RUN(a_total_step, r_cnt.total != $past(r_cnt.total), r_cnt.total == $past(r_cnt.total) + 32'd1, "total jumped")
    `AQA_ASSERT_RUN(a_total_cause, r_cnt.total != $past(r_cnt.total), $past(mv1 && r_s1.func == aqa_pkg::FUNC_RECORD), "total moved without a record")
    `AQA_ASSERT_RUN(a_paired_sticky, $past(r_cnt.paired), r_cnt.paired, "paired flag dropped")
    `AQA_ASSERT_RUN(a_max_grows, 1'b1, r_cnt.max_len >= $past(r_cnt.max_len), "longest read shrank")

endmodule
